/* sv/deq_pkg.sv */
// deq_pkg: command and status codes of the double-ended queue
// no dependencies; used by double_ended_queue
`default_nettype none

package deq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 2;

  // command carried by one input transaction
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4,
    OP_QUERY      = 3'd5
  } opcode_t;

  // status carried by one result transaction
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2,
    ST_DUMP_EMPTY = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* sv/double_ended_queue.sv */
// double_ended_queue: bounded deque of items held in a circular buffer
// depends on deq_pkg, deq_ram, deq_ptr
//
// Usage
//   in_ channel : one command per transaction (push front/back, pop
//                 front/back, dump, empty query); codes 6 and 7 are taken
//                 and dropped without a result.
//   out_ channel: result transactions; out_last marks the final result of
//                 a command. A dump gives one result per stored item, front
//                 to back, or a single result when the deque is empty.
//   Timing: push, query and failed pops put their result in the output
//   register on the cycle they are taken. A pop that finds an item reads
//   the storage RAM, whose read data is registered, so its result is loaded
//   from the S_POP state. A dump reads one stored item at a time through
//   the single RAM read port and waits while the output stalls. A new
//   command is taken once the previous one is done and the output register is free or being emptied.
//   Reset: empties the deque (front and count cleared); the RAM is not
//   cleared, only slots holding items ever reach the output.
//   Stall: while out_ready is low a pending result holds and in_ready drops.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ITEM_WIDTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [ITEM_WIDTH-1:0] in_item_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [ITEM_WIDTH-1:0] out_item_out,
  output logic      [1:0]            out_status,
  output logic                       out_is_empty,
  output logic                       out_last
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] dump_pos_r, dump_pos_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ITEM_WIDTH-1:0] out_item_r, out_item_nxt;
  deq_pkg::status_t      out_status_r, out_status_nxt;
  logic                  out_is_empty_r, out_is_empty_nxt;
  logic                  out_last_r, out_last_nxt;

  deq_pkg::opcode_t op_c;
  logic             accept_c;
  logic             out_free_c;
  logic             load_c;
  logic             full_c;
  logic             empty_c;
  logic             wr_en_c;
  logic [IDX_W-1:0] wr_addr_c;
  logic [IDX_W-1:0] rd_addr_c;
  logic [IDX_W-1:0] dump_inc_c;
  logic [ITEM_WIDTH-1:0] rd_data;

  logic [IDX_W-1:0] front_dec, front_inc, back_wr, back_rd;

  // slot storage
  deq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en_c),
    .wr_addr (wr_addr_c),
    .wr_data (in_item_in),
    .rd_addr (rd_addr_c),
    .rd_data (rd_data)
  );

  // front and back slot positions
  deq_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .front     (front_r),
    .count     (count_r),
    .front_dec (front_dec),
    .front_inc (front_inc),
    .back_wr   (back_wr),
    .back_rd   (back_rd)
  );

  // handshake
  assign op_c       = deq_pkg::opcode_t'(in_opcode);
  assign out_free_c = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && out_free_c;
  assign accept_c   = in_valid && in_ready;
  assign full_c     = (count_r == CNT_W'(DEPTH));
  assign empty_c    = (count_r == '0);
  assign dump_inc_c = (dump_pos_r == IDX_W'(DEPTH - 1)) ? '0 : dump_pos_r + 1'b1;

  // command sequencing and RAM access
  always_comb begin
    state_nxt        = state_r;
    front_nxt        = front_r;
    count_nxt        = count_r;
    dump_pos_nxt     = dump_pos_r;
    rem_nxt          = rem_r;
    wr_en_c          = 1'b0;
    wr_addr_c        = back_wr;
    rd_addr_c        = dump_pos_r;
    load_c           = 1'b0;
    out_item_nxt     = '0;
    out_status_nxt   = deq_pkg::ST_OK;
    out_is_empty_nxt = empty_c;
    out_last_nxt     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept_c) begin
          unique case (op_c)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              load_c = 1'b1;
              if (full_c) begin
                out_status_nxt = deq_pkg::ST_PUSH_FULL;
              end else begin
                wr_en_c          = 1'b1;
                count_nxt        = count_r + 1'b1;
                out_is_empty_nxt = 1'b0;
                if (op_c == deq_pkg::OP_PUSH_FRONT) begin
                  wr_addr_c = front_dec;
                  front_nxt = front_dec;
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (empty_c) begin
                load_c         = 1'b1;
                out_status_nxt = deq_pkg::ST_POP_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
                if (op_c == deq_pkg::OP_POP_FRONT) begin
                  rd_addr_c = front_r;
                  front_nxt = front_inc;
                end else begin
                  rd_addr_c = back_rd;
                end
              end
            end
            deq_pkg::OP_DUMP: begin
              if (empty_c) begin
                load_c         = 1'b1;
                out_status_nxt = deq_pkg::ST_DUMP_EMPTY;
              end else begin
                rd_addr_c    = front_r;
                dump_pos_nxt = front_r;
                rem_nxt      = count_r;
                state_nxt    = S_DUMP;
              end
            end
            deq_pkg::OP_QUERY: begin
              load_c = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // read data of the popped slot is ready; count already updated
        load_c       = 1'b1;
        out_item_nxt = rd_data;
        state_nxt    = S_IDLE;
      end
      S_DUMP: begin
        // hold the read address while stalled so the read data stays put
        out_item_nxt     = rd_data;
        out_is_empty_nxt = 1'b0;
        out_last_nxt     = (rem_r == CNT_W'(1));
        if (out_free_c) begin
          load_c       = 1'b1;
          rd_addr_c    = dump_inc_c;
          dump_pos_nxt = dump_inc_c;
          rem_nxt      = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (load_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // dump walk and result payload
  always_ff @(posedge clk) begin
    dump_pos_r <= dump_pos_nxt;
    rem_r      <= rem_nxt;
    if (load_c) begin
      out_item_r     <= out_item_nxt;
      out_status_r   <= out_status_nxt;
      out_is_empty_r <= out_is_empty_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item_out = out_item_r;
  assign out_status   = out_status_r;
  assign out_is_empty = out_is_empty_r;
  assign out_last     = out_last_r;

  // item count stays within the buffer
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("deque count exceeds depth");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_c |-> out_free_c)
    else $error("result register overwritten while stalled");

  // after a pop that found an item, the S_POP state loads it into the output register
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("pop result not loaded");

  // the dump counter is never zero and never exceeds the item count while walking
  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> ((rem_r != '0) && (rem_r <= count_r)))
    else $error("dump walk out of range");

endmodule

`default_nettype wire

/* sv/deq_ram.sv */
// deq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/deq_ptr.sv */
// deq_ptr: circular index arithmetic for the deque (front and back slots)
// no dependencies; DEPTH need not be a power of two
`default_nettype none

module deq_ptr #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic [$clog2(DEPTH)-1:0]   front,
  input  wire logic [$clog2(DEPTH+1)-1:0] count,
  output logic      [$clog2(DEPTH)-1:0]   front_dec,
  output logic      [$clog2(DEPTH)-1:0]   front_inc,
  output logic      [$clog2(DEPTH)-1:0]   back_wr,
  output logic      [$clog2(DEPTH)-1:0]   back_rd
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] sum_m1_c;

  // neighbors of the front slot, wrapping at the ends
  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;

  // slot after the last item, and the last item itself
  assign sum_c    = SUM_W'(front) + SUM_W'(count);
  assign sum_m1_c = sum_c - 1'b1;

  assign back_wr = (sum_c >= SUM_W'(DEPTH)) ? IDX_W'(sum_c - SUM_W'(DEPTH)) : IDX_W'(sum_c);
  assign back_rd = (sum_m1_c >= SUM_W'(DEPTH)) ? IDX_W'(sum_m1_c - SUM_W'(DEPTH))
                                               : IDX_W'(sum_m1_c);

endmodule

`default_nettype wire
